/* rtl/core/wptf_pkg.sv */
// Shared types, constants and fixed-point helpers of the waypoint path thinning filter.
`timescale 1ns / 1ps
`default_nettype none
package wptf_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  localparam logic [1:0]  CFG_Z_STEP = 2'd0;
  localparam logic [1:0]  CFG_COS_SQ = 2'd1;
  localparam logic [30:0] Z_STEP_RESET = 31'd3277;
  localparam logic [16:0] COS_SQ_RESET = 17'd65096;

  typedef logic [2:0][31:0] pt_t;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic               path_last;
  } wptf_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               path_end;
    logic               empty_path;
  } wptf_out_t;

  typedef struct packed {
    logic [30:0] z_thr;
    logic [16:0] cos_sq;
  } cfg_t;

  // one stage-one event: a passed point, or the end of the path
  typedef struct packed {
    logic done;
    pt_t  pt;
  } q_ent_t;

  // q - p, clamped to the signed coordinate range given by hi
  function automatic logic signed [32:0] sat_diff(input logic [31:0] q, input logic [31:0] p,
                                                  input logic signed [32:0] hi);
    logic signed [32:0] d;
    logic signed [32:0] lo;
    d  = $signed({q[31], q}) - $signed({p[31], p});
    lo = -hi - 33'sd1;
    if (d > hi) begin
      sat_diff = hi;
    end else if (d < lo) begin
      sat_diff = lo;
    end else begin
      sat_diff = d;
    end
  endfunction

  function automatic logic [31:0] mag(input logic signed [32:0] d);
    logic [32:0] u;
    u = d[32] ? 33'(-d) : 33'(d);
    return u[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/wptf_front.sv */
// Stage one: cursor walk, height-step detection and turn-back skip of waypoints.
`timescale 1ns / 1ps
`default_nettype none
module wptf_front #(
  parameter int COORD_WIDTH = wptf_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wptf_pkg::wptf_in_t in_data,
  input  wptf_pkg::cfg_t    cfg,
  output logic              q_push,
  output wptf_pkg::q_ent_t  q_entry,
  input  logic              q_full
);
  import wptf_pkg::*;

  localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);

  typedef enum logic [4:0] {
    F_IDLE    = 5'b00001,
    F_PREP    = 5'b00010,
    F_DOT     = 5'b00100,
    F_RESOLVE = 5'b01000,
    F_PUSH    = 5'b10000
  } f_state_t;

  f_state_t    state;
  pt_t         a_pt;
  pt_t         b_pt;
  pt_t         p_pt;
  pt_t         qa_pt;
  logic        p_last;
  logic [1:0]  cnt;
  logic [2:0][31:0] m1;
  logic [2:0][31:0] m2;
  logic [2:0]  sg;
  logic [63:0] pos;
  logic [63:0] neg;
  logic [63:0] prod;
  logic [1:0]  k;
  logic [1:0]  ki;
  logic        op_a;
  logic        op_p;
  logic        op_d;
  pt_t         a1;
  logic [1:0]  c1;
  logic        zstep;

  assign in_stall = (state != F_IDLE);
  assign ki       = (k == 2'd3) ? 2'd0 : k;

  always_comb begin
    a1 = a_pt;
    c1 = cnt;
    if (cnt == 2'd2) begin
      if (pos > neg) begin
        a1 = b_pt;
        c1 = 2'd1;
      end else begin
        c1 = 2'd0;
      end
    end
    zstep = mag(sat_diff(a1[AX_Z], p_pt[AX_Z], SAT_HI)) > 32'(cfg.z_thr);
  end

  always_comb begin
    q_entry.done = !op_a && !op_p;
    q_entry.pt   = op_a ? qa_pt : (op_p ? p_pt : '0);
    q_push       = (state == F_PUSH) && (op_a || op_p || op_d) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= 2'd0;
      op_a  <= 1'b0;
      op_p  <= 1'b0;
      op_d  <= 1'b0;
      k     <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            p_pt   <= {in_data.in_z, in_data.in_y, in_data.in_x};
            p_last <= in_data.path_last;
            state  <= (cnt == 2'd2) ? F_PREP : F_RESOLVE;
          end
        end
        F_PREP: begin
          for (int i = 0; i < 3; i++) begin
            m1[i] <= mag(sat_diff(b_pt[i], a_pt[i], SAT_HI));
            m2[i] <= mag(sat_diff(p_pt[i], b_pt[i], SAT_HI));
            sg[i] <= sat_diff(b_pt[i], a_pt[i], SAT_HI) < 0 ^
                     sat_diff(p_pt[i], b_pt[i], SAT_HI) < 0;
          end
          pos   <= 64'd0;
          neg   <= 64'd0;
          k     <= 2'd0;
          state <= F_DOT;
        end
        F_DOT: begin
          if (k != 2'd3) begin
            prod <= 64'(m1[ki]) * 64'(m2[ki]);
          end
          if (k != 2'd0) begin
            if (sg[2'(k - 2'd1)]) begin
              neg <= neg + prod;
            end else begin
              pos <= pos + prod;
            end
          end
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= F_RESOLVE;
          end
        end
        F_RESOLVE: begin
          op_a <= 1'b0;
          op_p <= 1'b0;
          op_d <= 1'b0;
          if (c1 == 2'd0) begin
            a_pt <= p_pt;
            cnt  <= p_last ? 2'd0 : 2'd1;
            op_d <= p_last;
          end else begin
            op_a  <= 1'b1;
            qa_pt <= a1;
            if (zstep) begin
              if (p_last) begin
                op_d <= 1'b1;
                cnt  <= 2'd0;
              end else begin
                a_pt <= a1;
                b_pt <= p_pt;
                cnt  <= 2'd2;
              end
            end else if (p_last) begin
              op_p <= 1'b1;
              op_d <= 1'b1;
              cnt  <= 2'd0;
            end else begin
              a_pt <= p_pt;
              cnt  <= 2'd1;
            end
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!(op_a || op_p || op_d)) begin
            state <= F_IDLE;
          end else if (!q_full) begin
            if (op_a) begin
              op_a <= 1'b0;
            end else if (op_p) begin
              op_p <= 1'b0;
            end else begin
              op_d <= 1'b0;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wptf_queue.sv */
// Short event queue between the stage-one front and the stage-two back.
`timescale 1ns / 1ps
`default_nettype none
module wptf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wptf_pkg::q_ent_t wr_entry,
  output logic             full,
  input  logic             pop,
  output wptf_pkg::q_ent_t rd_entry,
  output logic             empty
);
  import wptf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_ent_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full     = (fill == CW'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wptf_back.sv */
// Stage two: end-point keeping and exact turn-angle test on a shared 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none
module wptf_back #(
  parameter int COORD_WIDTH = wptf_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wptf_pkg::cfg_t     cfg,
  input  wptf_pkg::q_ent_t   q_entry,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wptf_pkg::wptf_out_t out_data
);
  import wptf_pkg::*;

  localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic [4:0] LAST_STEP = 5'd23;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_PREP = 4'b0010,
    B_CALC = 4'b0100,
    B_EMIT = 4'b1000
  } b_state_t;

  b_state_t     state;
  pt_t          prev;
  pt_t          latest;
  logic [1:0]   kcnt;
  q_ent_t       cur;
  wptf_out_t    em;
  logic [2:0][31:0] m1;
  logic [2:0][31:0] m2;
  logic [2:0]   sg;
  logic [63:0]  pos;
  logic [63:0]  neg;
  logic [63:0]  n1;
  logic [63:0]  n2;
  logic [63:0]  d;
  logic         dnp;
  logic [127:0] sq;
  logic [80:0]  r1;
  logic [144:0] r2;
  logic [63:0]  prod;
  logic [4:0]   step;
  logic [4:0]   tag;
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic         keep;
  wptf_out_t    em_latest;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign keep  = dnp || (145'({sq, 16'd0}) < r2);

  always_comb begin
    em_latest.out_x      = $signed(latest[AX_X]);
    em_latest.out_y      = $signed(latest[AX_Y]);
    em_latest.out_z      = $signed(latest[AX_Z]);
    em_latest.path_end   = 1'b0;
    em_latest.empty_path = 1'b0;
  end

  // operand selection for the shared multiplier
  always_comb begin
    ma = 32'd0;
    mb = 32'd0;
    case (step)
      5'd0:  begin ma = m1[0]; mb = m2[0]; end
      5'd1:  begin ma = m1[1]; mb = m2[1]; end
      5'd2:  begin ma = m1[2]; mb = m2[2]; end
      5'd3:  begin ma = m1[0]; mb = m1[0]; end
      5'd4:  begin ma = m1[1]; mb = m1[1]; end
      5'd5:  begin ma = m1[2]; mb = m1[2]; end
      5'd6:  begin ma = m2[0]; mb = m2[0]; end
      5'd7:  begin ma = m2[1]; mb = m2[1]; end
      5'd8:  begin ma = m2[2]; mb = m2[2]; end
      5'd9:  begin ma = d[31:0];  mb = d[31:0];  end
      5'd10: begin ma = d[31:0];  mb = d[63:32]; end
      5'd11: begin ma = d[63:32]; mb = d[31:0];  end
      5'd12: begin ma = d[63:32]; mb = d[63:32]; end
      5'd13: begin ma = 32'(cfg.cos_sq); mb = n1[31:0];  end
      5'd14: begin ma = 32'(cfg.cos_sq); mb = n1[63:32]; end
      5'd16: begin ma = r1[31:0];  mb = n2[31:0];  end
      5'd17: begin ma = r1[31:0];  mb = n2[63:32]; end
      5'd18: begin ma = r1[63:32]; mb = n2[31:0];  end
      5'd19: begin ma = r1[63:32]; mb = n2[63:32]; end
      5'd20: begin ma = 32'(r1[80:64]); mb = n2[31:0];  end
      5'd21: begin ma = 32'(r1[80:64]); mb = n2[63:32]; end
      default: begin ma = 32'd0; mb = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      kcnt      <= 2'd0;
      out_valid <= 1'b0;
      step      <= 5'd0;
    end else begin
      if (out_valid && !out_stall && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur <= q_entry;
            if (q_entry.done) begin
              if (kcnt != 2'd0) begin
                em <= '{out_x: em_latest.out_x, out_y: em_latest.out_y,
                        out_z: em_latest.out_z, path_end: 1'b1, empty_path: 1'b0};
              end else begin
                em <= '{out_x: '0, out_y: '0, out_z: '0, path_end: 1'b1, empty_path: 1'b1};
              end
              state <= B_EMIT;
            end else if (kcnt == 2'd0) begin
              latest <= q_entry.pt;
              kcnt   <= 2'd1;
            end else if (kcnt == 2'd1) begin
              em    <= em_latest;
              state <= B_EMIT;
            end else begin
              state <= B_PREP;
            end
          end
        end
        B_PREP: begin
          for (int i = 0; i < 3; i++) begin
            m1[i] <= mag(sat_diff(latest[i], prev[i], SAT_HI));
            m2[i] <= mag(sat_diff(cur.pt[i], latest[i], SAT_HI));
            sg[i] <= sat_diff(latest[i], prev[i], SAT_HI) < 0 ^
                     sat_diff(cur.pt[i], latest[i], SAT_HI) < 0;
          end
          pos   <= '0;
          neg   <= '0;
          n1    <= '0;
          n2    <= '0;
          sq    <= '0;
          r1    <= '0;
          r2    <= '0;
          step  <= 5'd0;
          state <= B_CALC;
        end
        B_CALC: begin
          prod <= 64'(ma) * 64'(mb);
          tag  <= step;
          // accumulate the product issued in the cycle before
          if (step != 5'd0) begin
            case (tag)
              5'd0:  if (sg[0]) neg <= neg + prod; else pos <= pos + prod;
              5'd1:  if (sg[1]) neg <= neg + prod; else pos <= pos + prod;
              5'd2:  if (sg[2]) neg <= neg + prod; else pos <= pos + prod;
              5'd3, 5'd4, 5'd5: n1 <= n1 + prod;
              5'd6, 5'd7, 5'd8: n2 <= n2 + prod;
              5'd9:  sq <= sq + 128'(prod);
              5'd10, 5'd11: sq <= sq + (128'(prod) << 32);
              5'd12: sq <= sq + (128'(prod) << 64);
              5'd13: r1 <= r1 + 81'(prod);
              5'd14: r1 <= r1 + (81'(prod) << 32);
              5'd16: r2 <= r2 + 145'(prod);
              5'd17, 5'd18: r2 <= r2 + (145'(prod) << 32);
              5'd19, 5'd20: r2 <= r2 + (145'(prod) << 64);
              5'd21: r2 <= r2 + (145'(prod) << 96);
              default: ;
            endcase
          end
          if (step == 5'd4) begin
            d   <= pos - neg;
            dnp <= !(pos > neg);
          end
          if (step == LAST_STEP) begin
            if (keep) begin
              em    <= em_latest;
              state <= B_EMIT;
            end else begin
              prev   <= latest;
              latest <= cur.pt;
              state  <= B_IDLE;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        B_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_data  <= em;
            out_valid <= 1'b1;
            if (cur.done) begin
              kcnt <= 2'd0;
            end else begin
              prev   <= latest;
              latest <= cur.pt;
              kcnt   <= 2'd2;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/waypoint_path_thinning_filter.sv */
// Top level of the waypoint path thinning filter: configuration, front, queue and back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | to block  | in_valid / in_stall  | in_data : in_x, in_y, in_z, path_last
//  out     | from block| out_valid / out_stall| out_data: out_x..out_z, path_end,
//          |           |                      |           empty_path
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The front takes one waypoint at a time and pushes up to three queue events
// for it; when a height step is pending, the turn-back dot product runs first
// on its 32x32 multiplier; a full queue holds it in place.
// The back runs each turn test as 21 partial products through one shared 32x32
// multiplier plus setup and compare, and emits when the point is kept; a first
// point is only stored, and an end of path or a second point goes straight to emit.
// A four-entry queue parts the two, and the output register parts the back
// from out_stall. Reset is synchronous; it restores both configuration registers
// and empties every window; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_path_thinning_filter #(
  parameter int COORD_WIDTH = wptf_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wptf_pkg::wptf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wptf_pkg::wptf_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import wptf_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  q_ent_t q_wr;
  q_ent_t q_rd;

  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.z_thr  <= Z_STEP_RESET;
      cfg.cos_sq <= COS_SQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_Z_STEP: cfg.z_thr  <= cfg_data;
        CFG_COS_SQ: cfg.cos_sq <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  wptf_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_push   (q_push),
    .q_entry  (q_wr),
    .q_full   (q_full)
  );

  wptf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty)
  );

  wptf_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_entry   (q_rd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("event queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("event queue read while empty");
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_path) |->
      (out_data.path_end && out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0))
    else $error("empty-path result malformed");
`endif

endmodule
`default_nettype wire
